FILE: hdl/vsfs_pkg.sv
// ----------------------------------------------------------------------------
// vsfs_pkg - shared types and constants for the segment/frame synchroniser
// Payload structs, queue entry, status codes, register indexes and sizes.
// ----------------------------------------------------------------------------
package vsfs_pkg;

	localparam int SEGMENTS_PER_FRAME = 4;
	localparam int MAX_PACKETS        = 64;
	localparam int MIN_PACKETS        = 21;
	localparam int QUEUE_DEPTH        = 4;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	// register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] CFG_PKTS_PER_SEG  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RESETS    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_INVALID   = 2'd2;

	localparam logic [6:0] PKTS_PER_SEG_RST = 7'd60;
	localparam logic [7:0] MAX_RESETS_RST   = 8'd30;
	localparam logic [5:0] MAX_INVALID_RST  = 6'd2;

	localparam logic [5:0] TAG_POSITION = 6'd20;
	localparam logic [7:0] TAG_NUMBER   = 8'd20;
	localparam logic [3:0] DISCARD_MARK = 4'hf;

	typedef enum logic [1:0] {
		ST_NORMAL    = 2'd0,
		ST_CS_RESET  = 2'd1,
		ST_SYNC_FAIL = 2'd2,
		ST_SYNC_LOST = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MODE_HUNT   = 2'd0,
		MODE_FILL   = 2'd1,
		MODE_SYNCED = 2'd2
	} sync_mode_t;

	typedef struct packed {
		logic [15:0] packet_id;
		logic [15:0] packet_crc;
	} hdr_t;

	typedef struct packed {
		logic        keep;
		logic [1:0]  segment_slot;
		logic [5:0]  packet_slot;
		logic [15:0] crc_out;
		logic [1:0]  status;
		logic        frame_end;
	} res_t;

	// classified header as it waits between front and back
	typedef struct packed {
		logic        discard;
		logic        num_ok;
		logic [3:0]  tag;
		logic [15:0] crc;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

FILE: hdl/video_spi_segment_frame_sync.sv
// ----------------------------------------------------------------------------
// video_spi_segment_frame_sync - segment and frame sync for video-over-SPI
// Places packet headers into segment/packet slots and tracks stream sync.
// ----------------------------------------------------------------------------
// Usage:
//   hdr channel: one beat per packet, id word and CRC word in wire order.
//   res channel: one beat per header: keep flag, segment and packet slot,
//   CRC, status (chip-select reset request, sync failed, sync lost) and
//   frame end marker. Status and frame end only appear on segment ends.
//   cfg channel: write packets_per_segment (0), max_sync_resets (1) and
//   max_invalid_frames (2); always ready. Write only while the block is
//   idle, i.e. every accepted header has produced its result beat.
// Pipeline:
//   A header accepted at edge t is registered and classified in the intake
//   stage, passes through the queue and is then loaded into the result
//   register, which raises res_valid. One beat per cycle is sustained while
//   res_stall is low; the back end updates its state once per popped beat.
// Reset: arst_n empties the queue, clears the result valid flag and returns all
// sync state to hunting; the registers return to 60, 30 and 2.
// Stall: a stalled result holds; the queue then fills and hdr_stall rises
// once the queue and the intake stage are both full.
// ----------------------------------------------------------------------------
module video_spi_segment_frame_sync
	import vsfs_pkg::*;
#(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   hdr_valid,
	output logic                   hdr_stall,
	input  hdr_t                   hdr,
	output logic                   res_valid,
	input  logic                   res_stall,
	output res_t                   res,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic        push;
	item_t       push_data;
	logic        pop;
	item_t       pop_data;
	queue_stat_t q_stat;

	// registers take every write at once
	assign cfg_ready = 1'b1;

	// intake: register and classify each header beat
	vsfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr_valid (hdr_valid),
		.hdr_stall (hdr_stall),
		.hdr       (hdr),
		.q_full    (q_stat.full),
		.push      (push),
		.push_data (push_data)
	);

	// decouple intake from the state machine
	vsfs_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	// advance sync state and hold the result beat
	vsfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (!q_stat.empty),
		.q_data    (pop_data),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// the queue can never read as full and empty together
	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty at once");

	// pop only from a non-empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	// a dropped discard packet carries no status and no frame end
	a_drop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.keep) |-> (res.status == ST_NORMAL && !res.frame_end))
		else $error("dropped packet carries status or frame end");

	// a header pushed into an empty queue while no result is held reaches the result register
	a_push_to_res: assert property (@(posedge clk) disable iff (!arst_n)
		(push && q_stat.empty && !res_valid) |-> ##2 res_valid)
		else $error("queued header did not reach the result register");

endmodule

FILE: hdl/vsfs_front.sv
// ----------------------------------------------------------------------------
// vsfs_front - header intake and classification
// Registers each accepted header as discard mark, number-byte check, tag and CRC.
// ----------------------------------------------------------------------------
module vsfs_front
	import vsfs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  hdr_valid,
	output logic  hdr_stall,
	input  hdr_t  hdr,
	input  logic  q_full,
	output logic  push,
	output item_t push_data
);

	logic  valid_s1;
	item_t item_s1;
	logic  take;

	assign push      = valid_s1 && !q_full;
	assign hdr_stall = valid_s1 && q_full;
	assign take      = hdr_valid && !hdr_stall;
	assign push_data = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.discard <= (hdr.packet_id[11:8] == DISCARD_MARK);
			item_s1.num_ok  <= (hdr.packet_id[7:0] == TAG_NUMBER);
			item_s1.tag     <= hdr.packet_id[15:12];
			item_s1.crc     <= hdr.packet_crc;
		end
	end

endmodule

FILE: hdl/vsfs_queue.sv
// ----------------------------------------------------------------------------
// vsfs_queue - short FIFO between front and back
// Register-based queue with simultaneous push and pop.
// ----------------------------------------------------------------------------
module vsfs_queue
	import vsfs_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  item_t       push_data,
	input  logic        pop,
	output item_t       pop_data,
	output queue_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full  = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: hdl/vsfs_back.sv
// ----------------------------------------------------------------------------
// vsfs_back - sync state machine and result register
// Places each queued header into its slots, tracks sync and drives results.
// ----------------------------------------------------------------------------
module vsfs_back
	import vsfs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   q_valid,
	input  item_t                  q_data,
	output logic                   pop,
	output logic                   res_valid,
	input  logic                   res_stall,
	output res_t                   res
);

	localparam logic [6:0] N_MIN = 7'(MIN_PACKETS);
	localparam logic [6:0] N_MAX = 7'(MAX_PACKETS);
	localparam logic [2:0] SEG_COUNT = 3'(SEGMENTS_PER_FRAME);

	logic [6:0] pps_q;
	logic [7:0] max_rst_q;
	logic [5:0] max_inv_q;

	sync_mode_t mode_q, mode_n;
	logic [5:0] pos_q, pos_n;
	logic [1:0] seg_q, seg_n;
	logic [4:0] tag20_q, tag20_n;
	logic [7:0] rst_cnt_q, rst_cnt_n;
	logic [7:0] retry_q, retry_n;

	logic       res_valid_q;
	res_t       res_q;
	res_t       res_n;

	logic [6:0] seg_len;
	logic       last;
	logic [2:0] seg_inc;
	logic [8:0] rst_inc;

	assign pop       = q_valid && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		if (pps_q < N_MIN) begin
			seg_len = N_MIN;
		end else if (pps_q > N_MAX) begin
			seg_len = N_MAX;
		end else begin
			seg_len = pps_q;
		end
	end

	assign last    = ({1'b0, pos_q} + 7'd1) >= seg_len;
	assign seg_inc = {1'b0, seg_q} + 3'd1;
	assign rst_inc = {1'b0, rst_cnt_q} + 9'd1;

	always_comb begin
		mode_n    = mode_q;
		pos_n     = pos_q;
		seg_n     = seg_q;
		tag20_n   = tag20_q;
		rst_cnt_n = rst_cnt_q;
		retry_n   = retry_q;

		res_n.keep         = 1'b1;
		res_n.segment_slot = seg_q;
		res_n.packet_slot  = pos_q;
		res_n.crc_out      = q_data.crc;
		res_n.status       = ST_NORMAL;
		res_n.frame_end    = 1'b0;

		if (pos_q == '0 && q_data.discard) begin
			res_n.keep = 1'b0;
		end else begin
			if (pos_q == '0) begin
				tag20_n = '0;
			end
			if (pos_q == TAG_POSITION) begin
				tag20_n = {q_data.num_ok, q_data.tag};
			end
			if (last) begin
				pos_n = '0;
				case (mode_q)
					MODE_FILL: begin
						if (seg_inc >= SEG_COUNT) begin
							res_n.frame_end = 1'b1;
							seg_n   = '0;
							mode_n  = MODE_SYNCED;
							retry_n = '0;
						end else begin
							seg_n = seg_inc[1:0];
						end
					end
					MODE_SYNCED: begin
						if (tag20_n[3:0] != {1'b0, seg_inc}) begin
							if (retry_q > {max_inv_q, 2'b00}) begin
								res_n.status = ST_SYNC_LOST;
								mode_n    = MODE_HUNT;
								seg_n     = '0;
								retry_n   = '0;
								rst_cnt_n = '0;
							end else begin
								retry_n = retry_q + 8'd1;
							end
						end else if (seg_inc >= SEG_COUNT) begin
							res_n.frame_end = 1'b1;
							seg_n   = '0;
							retry_n = '0;
						end else begin
							seg_n = seg_inc[1:0];
						end
					end
					default: begin
						// hunting: check each segment at its last packet
						mode_n = MODE_HUNT;
						seg_n  = '0;
						if (!tag20_n[4]) begin
							if (rst_inc >= {1'b0, max_rst_q}) begin
								res_n.status = ST_SYNC_FAIL;
								rst_cnt_n    = '0;
							end else begin
								res_n.status = ST_CS_RESET;
								rst_cnt_n    = rst_inc[7:0];
							end
						end else if (tag20_n[3:0] == 4'd1) begin
							rst_cnt_n = '0;
							retry_n   = '0;
							if (SEGMENTS_PER_FRAME <= 1) begin
								res_n.frame_end = 1'b1;
								mode_n = MODE_SYNCED;
							end else begin
								seg_n  = 2'd1;
								mode_n = MODE_FILL;
							end
						end
					end
				endcase
			end else begin
				pos_n = pos_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_HUNT;
			pos_q     <= '0;
			seg_q     <= '0;
			tag20_q   <= '0;
			rst_cnt_q <= '0;
			retry_q   <= '0;
		end else if (pop) begin
			mode_q    <= mode_n;
			pos_q     <= pos_n;
			seg_q     <= seg_n;
			tag20_q   <= tag20_n;
			rst_cnt_q <= rst_cnt_n;
			retry_q   <= retry_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pps_q     <= PKTS_PER_SEG_RST;
			max_rst_q <= MAX_RESETS_RST;
			max_inv_q <= MAX_INVALID_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_PKTS_PER_SEG: pps_q     <= cfg_data[6:0];
				CFG_MAX_RESETS:   max_rst_q <= cfg_data;
				CFG_MAX_INVALID:  max_inv_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_n;
		end
	end

endmodule

FILE: tb/tb_video_spi_segment_frame_sync.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_video_spi_segment_frame_sync - self-checking bench for the segment sync
// Feeds packet headers, mostly as well-formed segments and frames with random
// faults, runs a cycle-free tracker of the expected slot and sync status for
// every accepted header, and checks each result beat against it in order.
// Register settings and handshake pacing change from phase to phase.
// ----------------------------------------------------------------------------
module tb_video_spi_segment_frame_sync;
	import vsfs_pkg::*;

	localparam int RESET_CYCLES   = 4;
	localparam int TOTAL_HEADERS  = 25 + 1300;	// directed part plus random part
	localparam int PHASE_HEADERS  = 100;
	localparam int DRAIN_CYCLES   = 6;		// intake stage, queue and result register plus margin
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int REPORT_LIMIT   = 200;
	localparam int BUSY_PCT       = 83;
	localparam int LIGHT_PCT      = 11;

	// no register sits behind this index; a write to it must change nothing
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum int {
		PACE_FULL,
		PACE_SENDER_IDLE,
		PACE_RECEIVER_STALL,
		PACE_BOTH,
		PACE_PRESSURE
	} pace_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   hdr_valid = 1'b0;
	logic                   hdr_stall;
	hdr_t                   hdr       = '0;
	logic                   res_valid;
	logic                   res_stall = 1'b0;
	res_t                   res;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// headers waiting for the driver, and placements waiting for their beat
	hdr_t  headers_to_send[$];
	res_t  placements_due[$];
	pace_t pace = PACE_FULL;
	int    headers_queued = 0;
	int    mismatches     = 0;
	int    hold_count     = 0;
	int    quiet_cycles   = 0;

	// stimulus side: its own idea of the packet position and the frame slot
	int gen_pos  = 0;
	int gen_slot = 0;

	// tracker copy of the registers and the sync state
	logic [6:0]  seg_len_reg     = PKTS_PER_SEG_RST;
	logic [7:0]  max_resets_reg  = MAX_RESETS_RST;
	logic [5:0]  max_invalid_reg = MAX_INVALID_RST;
	sync_mode_t  trk_mode        = MODE_HUNT;
	int          trk_pkt         = 0;
	int          trk_seg         = 0;
	logic [4:0]  trk_tag20       = '0;	// bit 4: number byte was 20, 3:0 tag
	int          trk_resets      = 0;
	int          trk_retries     = 0;

	video_spi_segment_frame_sync DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr_valid (hdr_valid),
		.hdr_stall (hdr_stall),
		.hdr       (hdr),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Segment length as the block uses it: out-of-range settings clamp.
	function automatic int segment_length();
		int len;
		len = int'(seg_len_reg);
		if (len < MIN_PACKETS) len = MIN_PACKETS;
		if (len > MAX_PACKETS) len = MAX_PACKETS;
		return len;
	endfunction

	// Work out where one accepted header lands and advance the sync state.
	function automatic res_t place_packet(hdr_t h);
		res_t       r;
		logic [3:0] tag;
		logic       num_ok;
		r.keep         = 1'b1;
		r.segment_slot = trk_seg[1:0];
		r.packet_slot  = trk_pkt[5:0];
		r.crc_out      = h.packet_crc;
		r.status       = ST_NORMAL;
		r.frame_end    = 1'b0;
		if (trk_pkt == 0 && h.packet_id[11:8] == DISCARD_MARK) begin
			// drop a discard at a segment start; the position stays put
			r.keep = 1'b0;
		end else begin
			if (trk_pkt == 0)
				trk_tag20 = '0;
			if (trk_pkt == int'(TAG_POSITION))
				trk_tag20 = {h.packet_id[7:0] == TAG_NUMBER, h.packet_id[15:12]};
			if (trk_pkt + 1 >= segment_length()) begin
				// segment end: a position already past the end counts too
				tag     = trk_tag20[3:0];
				num_ok  = trk_tag20[4];
				trk_pkt = 0;
				case (trk_mode)
				MODE_FILL: begin
					// rest of the frame after lock is taken unchecked
					trk_seg++;
					if (trk_seg >= SEGMENTS_PER_FRAME) begin
						r.frame_end = 1'b1;
						trk_seg     = 0;
						trk_mode    = MODE_SYNCED;
						trk_retries = 0;
					end
				end
				MODE_SYNCED: begin
					if (int'(tag) != trk_seg + 1) begin
						// repeat the segment, or give up on sync
						if (trk_retries > int'(max_invalid_reg) * 4) begin
							r.status    = ST_SYNC_LOST;
							trk_mode    = MODE_HUNT;
							trk_seg     = 0;
							trk_retries = 0;
							trk_resets  = 0;
						end else begin
							trk_retries++;
						end
					end else begin
						trk_seg++;
						if (trk_seg >= SEGMENTS_PER_FRAME) begin
							r.frame_end = 1'b1;
							trk_seg     = 0;
							trk_retries = 0;
						end
					end
				end
				default: begin
					// hunting; the unused mode code behaves the same
					trk_mode = MODE_HUNT;
					trk_seg  = 0;
					if (!num_ok) begin
						trk_resets++;
						if (trk_resets >= int'(max_resets_reg)) begin
							r.status   = ST_SYNC_FAIL;
							trk_resets = 0;
						end else begin
							r.status = ST_CS_RESET;
						end
					end else if (tag == 4'd1) begin
						trk_resets  = 0;
						trk_retries = 0;
						if (SEGMENTS_PER_FRAME <= 1) begin
							r.frame_end = 1'b1;
							trk_mode    = MODE_SYNCED;
						end else begin
							trk_seg  = 1;
							trk_mode = MODE_FILL;
						end
					end
				end
				endcase
			end else begin
				trk_pkt++;
			end
		end
		return r;
	endfunction

	function automatic int idle_pct(bit receiver_side);
		case (pace)
		PACE_SENDER_IDLE:    return receiver_side ? 0 : BUSY_PCT;
		PACE_RECEIVER_STALL: return receiver_side ? BUSY_PCT : 0;
		PACE_BOTH:           return LIGHT_PCT;
		default:             return 0;
		endcase
	endfunction

	function automatic void check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	// Queue one header and follow the packet position it leads to.
	function automatic void queue_header(input logic [15:0] id, input logic [15:0] crc);
		hdr_t h;
		h.packet_id  = id;
		h.packet_crc = crc;
		headers_to_send.push_back(h);
		headers_queued++;
		if (!(gen_pos == 0 && id[11:8] == DISCARD_MARK))
			gen_pos = (gen_pos + 1 >= segment_length()) ? 0 : gen_pos + 1;
	endfunction

	// One segment with random content, mostly well-formed. Faults: wrong tag,
	// wrong number byte at packet 20, stray packets ahead, tag in the wrong spot.
	task automatic queue_segment();
		int          kind;
		int          tag_at;
		logic [3:0]  tag;
		logic [7:0]  number;
		logic [15:0] id;
		kind   = $urandom_range(99);
		tag    = 4'(gen_slot + 1);
		number = TAG_NUMBER;
		tag_at = int'(TAG_POSITION);
		if (kind >= 65 && kind < 77)
			tag = tag + 4'($urandom_range(1, 15));
		else if (kind >= 77 && kind < 87) begin
			number = 8'($urandom_range(0, 255));
			if (number == TAG_NUMBER)
				number++;
		end else if (kind >= 87 && kind < 94)
			repeat ($urandom_range(1, 3)) queue_header(16'($urandom), 16'($urandom));
		else if (kind >= 94) begin
			tag_at = $urandom_range(0, MAX_PACKETS - 1);
			if (tag_at == int'(TAG_POSITION))
				tag_at--;
		end
		if (gen_pos == 0 && $urandom_range(4) == 0)
			repeat ($urandom_range(1, 2))
				queue_header({4'($urandom), DISCARD_MARK, 8'($urandom)}, 16'($urandom));
		do begin
			if (gen_pos == tag_at) begin
				id = {tag, 4'($urandom_range(0, 14)), number};
			end else begin
				id = 16'($urandom);
				// keep the first packet of the body so the segment does start
				if (gen_pos == 0 && id[11:8] == DISCARD_MARK)
					id[11:8] = 4'($urandom_range(0, 14));
			end
			queue_header(id, 16'($urandom));
		end while (gen_pos != 0);
		// a sender repeats a rejected segment, otherwise moves on a slot
		if (kind < 65 || (kind >= 77 && kind < 94))
			gen_slot = (gen_slot + 1) % SEGMENTS_PER_FRAME;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
		CFG_PKTS_PER_SEG: seg_len_reg     = val[6:0];
		CFG_MAX_RESETS:   max_resets_reg  = val;
		CFG_MAX_INVALID:  max_invalid_reg = val[5:0];
		default: ;
		endcase
	endtask

	// Wait for every queued header to come back as a beat, then let the pipe settle.
	task automatic wait_idle();
		while (headers_to_send.size() != 0 || hdr_valid || placements_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Driver: hold a stalled beat, else record the accepted one and offer the next.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hdr_valid && !hdr_stall)
				placements_due.push_back(place_packet(hdr));
			if (!(hdr_valid && hdr_stall)) begin
				if (headers_to_send.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
					hdr       <= headers_to_send.pop_front();
					hdr_valid <= 1'b1;
				end else begin
					hdr_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result beat against the oldest placement, drive stall.
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (placements_due.size() == 0) begin
					mismatches++;
					$display("%0t ns: result beat with nothing expected, got %h", $time, res);
				end else begin
					want = placements_due.pop_front();
					check_field("keep", want.keep, res.keep);
					check_field("segment_slot", want.segment_slot, res.segment_slot);
					check_field("packet_slot", want.packet_slot, res.packet_slot);
					check_field("crc_out", want.crc_out, res.crc_out);
					check_field("status", want.status, res.status);
					check_field("frame_end", want.frame_end, res.frame_end);
				end
			end
			if (pace == PACE_PRESSURE) begin
				// hold off long enough for the block to back up into its input
				res_stall <= (hold_count < HOLD_CYCLES);
				if (hold_count < HOLD_CYCLES)
					hold_count++;
			end else begin
				hold_count = 0;
				res_stall <= ($urandom_range(99) < idle_pct(1'b1));
			end
		end
	end

	// Watchdog: give up when no beat moves on any channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((hdr_valid && !hdr_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t ns: no beat moved for %0d cycles", $time, quiet_cycles);
				$display("** video_spi_segment_frame_sync: FAILED **");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int ph;
		int seg_count;
		int phase_start;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: shortest segment, field extremes, discards in and out of place.
		write_reg(CFG_PKTS_PER_SEG, 8'd21);
		write_reg(CFG_MAX_RESETS, 8'd1);
		write_reg(CFG_MAX_INVALID, 8'd0);
		@(negedge clk);
		queue_header(16'hffff, 16'hffff);		// discard at segment start: dropped
		queue_header(16'h0f00, 16'h0000);
		queue_header(16'h0000, 16'h0000);		// smallest id, kept
		queue_header(16'h0fff, 16'hffff);		// discard mark mid-segment: kept
		for (int i = 2; i < int'(TAG_POSITION); i++)
			queue_header({4'(i), 4'h3, 8'(i)}, 16'(i * 4099));
		queue_header({4'd1, 4'h0, TAG_NUMBER}, 16'h8001);	// tag 1 at packet 20: lock
		queue_header({4'd2, DISCARD_MARK, TAG_NUMBER}, 16'h7fff);
		queue_header(16'h8000, 16'h0001);
		gen_slot = 1;
		wait_idle();

		// Random phases: extremes of the registers first, then mixed settings.
		ph = 0;
		while (headers_queued < TOTAL_HEADERS) begin
			case (ph)
			0: begin
				write_reg(CFG_PKTS_PER_SEG, 8'd21);
				write_reg(CFG_MAX_RESETS, MAX_RESETS_RST);
				write_reg(CFG_MAX_INVALID, 8'd2);
			end
			1: begin
				write_reg(CFG_PKTS_PER_SEG, 8'd0);		// clamps up to the minimum
				write_reg(CFG_MAX_RESETS, 8'd0);		// every bad segment fails sync
				write_reg(CFG_MAX_INVALID, 8'd0);
			end
			2: begin
				write_reg(CFG_PKTS_PER_SEG, 8'hff);		// clamps down to the maximum
				write_reg(CFG_MAX_RESETS, 8'hff);
				write_reg(CFG_MAX_INVALID, 8'hff);
				write_reg(CFG_UNUSED, 8'h5a);
			end
			3: begin
				write_reg(CFG_PKTS_PER_SEG, 8'd64);
				write_reg(CFG_MAX_RESETS, 8'd1);
				write_reg(CFG_MAX_INVALID, 8'd63);
			end
			4: begin
				write_reg(CFG_PKTS_PER_SEG, 8'd20);
				write_reg(CFG_MAX_RESETS, 8'd2);
				write_reg(CFG_MAX_INVALID, 8'd1);
			end
			default: begin
				write_reg(CFG_PKTS_PER_SEG, ($urandom_range(9) == 0) ?
					8'($urandom_range(0, 255)) : 8'($urandom_range(21, 24)));
				write_reg(CFG_MAX_RESETS, ($urandom_range(4) == 0) ?
					8'($urandom_range(0, 255)) : 8'($urandom_range(0, 4)));
				write_reg(CFG_MAX_INVALID, ($urandom_range(4) == 0) ?
					8'($urandom_range(0, 255)) : 8'($urandom_range(0, 1)));
				if ($urandom_range(2) == 0)
					write_reg(CFG_UNUSED, 8'($urandom));
			end
			endcase
			@(negedge clk);
			pace = (ph == 2) ? PACE_PRESSURE : pace_t'(ph % 4);
			// a new length may leave the old position past the end
			gen_pos = (trk_pkt + 1 >= segment_length()) ? segment_length() - 1 : trk_pkt;
			phase_start = headers_queued;
			seg_count = 0;
			while (seg_count < 3 || headers_queued - phase_start < PHASE_HEADERS) begin
				queue_segment();
				seg_count++;
			end
			wait_idle();
			ph++;
		end

		if (mismatches == 0 && placements_due.size() == 0)
			$display("** video_spi_segment_frame_sync: PASSED **");
		else
			$display("** video_spi_segment_frame_sync: FAILED **");
		$finish;
	end

endmodule
